FILE: design/rational_arith_reduce_macros.svh
// Assertion macros shared by the rational reduction block.
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH

// Implication checked on every rising edge of clk, quiet during reset.
`define RAR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold on a rising edge of clk.
`define RAR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: design/rar_pkg.sv
// Types, codes and helper functions for the rational reduction block.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;

	localparam int WORD_BITS = 32;
	localparam int WIDE_W    = 2 * WORD_BITS;
	localparam int CNT_W     = $clog2(WIDE_W);
	localparam int NUM_W     = 64;
	localparam int DEN_W     = 63;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WIDE_W - 1);
	localparam logic [1:0] MUL_LAST = 2'd2;

	// Operation codes.
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} rar_in_t;

	typedef struct packed {
		logic [NUM_W-1:0] res_num;
		logic [DEN_W-1:0] res_den;
		logic [1:0]       status;
	} rar_out_t;

	typedef struct packed {
		logic                 neg;
		logic [WORD_BITS-1:0] mag;
	} rar_smag_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_GCD,
		ST_DIV,
		ST_FIN
	} rar_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       sum_en;
		logic       gcd_en;
		logic       div_init;
		logic       div_en;
		logic       out_load;
	} rar_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic stat_ok;
		logic gcd_done;
	} rar_sts_t;

	// Reads the low word as two's complement and splits it into sign and magnitude.
	function automatic rar_smag_t take_word(logic [31:0] raw);
		logic [WORD_BITS-1:0] v;
		rar_smag_t r;
		v = raw[WORD_BITS-1:0];
		r.neg = v[WORD_BITS-1];
		r.mag = v[WORD_BITS-1] ? WORD_BITS'(~v + WORD_BITS'(1)) : v;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/rar_datapath.sv
// Datapath: operand registers, shared multiplier, signed sum, binary gcd and two dividers.
`timescale 1ns / 1ps
`default_nettype none
module rar_datapath import rar_pkg::*; (
	input  wire logic     clk,
	input  wire rar_in_t  item,
	input  wire rar_cmd_t cmd,
	output rar_sts_t      sts,
	output rar_out_t      res
);

	logic [1:0]        kind_q;
	rar_smag_t         an_q, ad_q, bn_q, bd_q;
	logic [WIDE_W-1:0] p_mag_q [3];
	logic              p_neg_q [3];
	logic              res_neg_q;
	logic [1:0]        stat_q;
	logic [WIDE_W-1:0] n_mag_q, d_mag_q;
	logic [WIDE_W-1:0] x_q, y_q, g_q;
	logic [CNT_W-1:0]  k_q;
	logic [WIDE_W-1:0] qn_q, qd_q;
	logic [WIDE_W:0]   rn_q, rd_q;
	rar_out_t          res_q;

	// Multiplier operand selection.
	rar_smag_t         op_x, op_y;
	logic              flip_y;
	logic [WIDE_W-1:0] prod;
	logic              prod_neg;

	always_comb begin
		op_x = an_q;
		op_y = bd_q;
		flip_y = 1'b0;
		case (cmd.mul_sel)
			2'd0: begin
				op_x = an_q;
				op_y = (kind_q == KIND_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				op_x = ad_q;
				op_y = bn_q;
				flip_y = (kind_q == KIND_SUB);
			end
			default: begin
				op_x = ad_q;
				op_y = (kind_q == KIND_DIV) ? bn_q : bd_q;
			end
		endcase
		prod = WIDE_W'(op_x.mag) * WIDE_W'(op_y.mag);
		prod_neg = (op_x.neg ^ op_y.neg ^ flip_y) && (prod != '0);
	end

	// Signed sum of the two cross products, overflow and zero checks.
	logic [WIDE_W-1:0] s_mag;
	logic              s_neg;
	logic              n_neg;
	logic [WIDE_W-1:0] n_mag;
	logic              ovf, zero_err;

	always_comb begin
		if (p_neg_q[0] == p_neg_q[1]) begin
			s_mag = p_mag_q[0] + p_mag_q[1];
			s_neg = p_neg_q[0];
		end else if (p_mag_q[0] >= p_mag_q[1]) begin
			s_mag = p_mag_q[0] - p_mag_q[1];
			s_neg = p_neg_q[0];
		end else begin
			s_mag = p_mag_q[1] - p_mag_q[0];
			s_neg = p_neg_q[1];
		end
		if (s_mag == '0) begin
			s_neg = 1'b0;
		end
		if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
			n_mag = s_mag;
			n_neg = s_neg;
		end else begin
			n_mag = p_mag_q[0];
			n_neg = p_neg_q[0];
		end
		ovf = n_mag[WIDE_W-1] && (!n_neg || n_mag[WIDE_W-2:0] != '0);
		zero_err = (ad_q.mag == '0) || (bd_q.mag == '0) ||
			(kind_q == KIND_DIV && bn_q.mag == '0);
	end

	// One restoring division step for each of the two quotients.
	logic [WIDE_W:0] rn_sh, rd_sh;
	logic            qn_bit, qd_bit;

	always_comb begin
		rn_sh = {rn_q[WIDE_W-1:0], qn_q[WIDE_W-1]};
		rd_sh = {rd_q[WIDE_W-1:0], qd_q[WIDE_W-1]};
		qn_bit = (rn_sh >= {1'b0, g_q});
		qd_bit = (rd_sh >= {1'b0, g_q});
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.kind;
			an_q <= take_word(item.a_num);
			ad_q <= take_word(item.a_den);
			bn_q <= take_word(item.b_num);
			bd_q <= take_word(item.b_den);
		end
		if (cmd.mul_en) begin
			p_mag_q[cmd.mul_sel] <= prod;
			p_neg_q[cmd.mul_sel] <= prod_neg;
		end
		if (cmd.sum_en) begin
			stat_q <= zero_err ? STAT_ZERO : (ovf ? STAT_OVF : STAT_OK);
			res_neg_q <= (n_neg != p_neg_q[2]) && (n_mag != '0);
			n_mag_q <= n_mag;
			d_mag_q <= p_mag_q[2];
			x_q <= n_mag;
			y_q <= p_mag_q[2];
			k_q <= '0;
		end
		// Binary gcd: one halving or one subtraction per cycle.
		if (cmd.gcd_en && x_q != '0) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + CNT_W'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (cmd.div_init) begin
			g_q <= y_q << k_q;
			qn_q <= n_mag_q;
			qd_q <= d_mag_q;
			rn_q <= '0;
			rd_q <= '0;
		end
		if (cmd.div_en) begin
			rn_q <= qn_bit ? (rn_sh - {1'b0, g_q}) : rn_sh;
			rd_q <= qd_bit ? (rd_sh - {1'b0, g_q}) : rd_sh;
			qn_q <= {qn_q[WIDE_W-2:0], qn_bit};
			qd_q <= {qd_q[WIDE_W-2:0], qd_bit};
		end
		if (cmd.out_load) begin
			res_q.status <= stat_q;
			if (stat_q == STAT_OK) begin
				res_q.res_num <= res_neg_q ? NUM_W'(-qn_q) : NUM_W'(qn_q);
				res_q.res_den <= DEN_W'(qd_q);
			end else begin
				res_q.res_num <= '0;
				res_q.res_den <= '0;
			end
		end
	end

	assign sts.stat_ok = (stat_q == STAT_OK);
	assign sts.gcd_done = (x_q == '0);
	assign res = res_q;

endmodule
`default_nettype wire

FILE: design/rar_ctrl.sv
// Controller: sequences the multiply, sum, gcd, divide and output steps of one item.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_reduce_macros.svh"
module rar_ctrl import rar_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	input  wire rar_sts_t sts,
	output rar_cmd_t      cmd
);

	rar_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             accept, out_free;

	assign accept = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nxt = ST_MUL;
			ST_MUL:  if (cnt_q[1:0] == MUL_LAST) state_nxt = ST_SUM;
			ST_SUM:  state_nxt = ST_GCD;
			ST_GCD: begin
				if (!sts.stat_ok) state_nxt = ST_FIN;
				else if (sts.gcd_done) state_nxt = ST_DIV;
			end
			ST_DIV:  if (cnt_q == DIV_LAST) state_nxt = ST_FIN;
			ST_FIN:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		cmd.mul_sel = cnt_q[1:0];
		unique case (state_q)
			ST_IDLE: cmd.load = accept;
			ST_MUL:  cmd.mul_en = 1'b1;
			ST_SUM:  cmd.sum_en = 1'b1;
			ST_GCD: begin
				cmd.gcd_en = sts.stat_ok;
				cmd.div_init = sts.stat_ok && sts.gcd_done;
			end
			ST_DIV:  cmd.div_en = 1'b1;
			ST_FIN:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	// State, step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_nxt != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	`RAR_ASSERT(a_accept_starts, accept |=> (state_q == ST_MUL && cnt_q == '0), "item not started")
	`RAR_ASSERT(a_load_shows, cmd.out_load |=> rsp_valid, "loaded result not offered")
	`RAR_ASSERT(a_div_length, (state_q == ST_DIV && cnt_q == DIV_LAST) |=> state_q == ST_FIN, "division overran")
	`RAR_NEVER(a_gcd_wait, state_q == ST_GCD && sts.stat_ok && !sts.gcd_done && !cmd.gcd_en, "gcd stalled")

endmodule
`default_nettype wire

FILE: design/rational_arith_reduce.sv
// Top level of the rational add, subtract, multiply and divide block with gcd reduction.
// Usage:
//   The request channel carries one item: an operation kind and two signed fractions.
//   The response channel returns one item per request: the numerator and positive
//   denominator in lowest terms and a status (ok, zero denominator, overflow).
//   Both channels use valid and stall; an item moves when valid is high and stall low.
// Timing:
//   One item is worked at a time. After acceptance it forms three products on the
//   multiplier, then a sum step, a binary gcd of one halving or subtraction per cycle
//   (which does no steps for a zero numerator), then a restoring division that
//   produces numerator and denominator quotients together, and an output step.
//   Items with a bad denominator or overflow skip the gcd and divider.
// Reset and stall:
//   Reset clears the controller; no result is offered after it. A finished result
//   waits in the output register while the receiver stalls, and the next request is
//   taken meanwhile; it then waits at its final step until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce import rar_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire rar_in_t req_item,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output rar_out_t     rsp_item
);

	rar_cmd_t cmd;
	rar_sts_t sts;

	// Sequencer.
	rar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic.
	rar_datapath u_datapath (
		.clk  (clk),
		.item (req_item),
		.cmd  (cmd),
		.sts  (sts),
		.res  (rsp_item)
	);

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the rational fraction arithmetic and reduction block.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected reduced fractions in arrival order and checks each result item.
class fraction_board;
	rar_pkg::rar_out_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Splits the low word of an operand into sign and magnitude.
	function void split(input logic [31:0] raw, output bit neg, output logic [63:0] mag);
		logic [rar_pkg::WORD_BITS-1:0] v;
		v = raw[rar_pkg::WORD_BITS-1:0];
		neg = v[rar_pkg::WORD_BITS-1];
		mag = 64'(neg ? rar_pkg::WORD_BITS'(-v) : v);
	endfunction

	// Adds two sign and magnitude values.
	function void sm_add(input bit xn, input logic [63:0] xm, input bit yn,
			input logic [63:0] ym, output bit rn, output logic [63:0] rm);
		if (xn == yn) begin
			rm = xm + ym;
			rn = xn;
		end else if (xm >= ym) begin
			rm = xm - ym;
			rn = xn;
		end else begin
			rm = ym - xm;
			rn = yn;
		end
		if (rm == 0)
			rn = 0;
	endfunction

	// Works out the reduced fraction for one accepted request item.
	function void note_request(input rar_pkg::rar_in_t it);
		bit an, ad, bn, bd, nn, dn, p1n, p2n, neg;
		logic [63:0] am, adm, bm, bdm, nm, dm, p1, p2, x, y, t, lim;
		rar_pkg::rar_out_t r;
		split(it.a_num, an, am);
		split(it.a_den, ad, adm);
		split(it.b_num, bn, bm);
		split(it.b_den, bd, bdm);
		r = '0;
		lim = 64'd1 << (2 * rar_pkg::WORD_BITS - 1);
		if (adm == 0 || bdm == 0 || (it.kind == rar_pkg::KIND_DIV && bm == 0)) begin
			r.status = rar_pkg::STAT_ZERO;
			pending.push_back(r);
			return;
		end
		if (it.kind == rar_pkg::KIND_SUB)
			bn = !bn && bm != 0;
		case (it.kind)
			rar_pkg::KIND_ADD, rar_pkg::KIND_SUB: begin
				p1 = am * bdm;
				p1n = (an != bd) && p1 != 0;
				p2 = bm * adm;
				p2n = (bn != ad) && p2 != 0;
				sm_add(p1n, p1, p2n, p2, nn, nm);
				dm = adm * bdm;
				dn = ad != bd;
			end
			rar_pkg::KIND_MUL: begin
				nm = am * bm;
				nn = (an != bn) && nm != 0;
				dm = adm * bdm;
				dn = ad != bd;
			end
			default: begin
				nm = am * bdm;
				nn = (an != bd) && nm != 0;
				dm = adm * bm;
				dn = ad != bn;
			end
		endcase
		if (nn ? (nm > lim) : (nm >= lim)) begin
			r.status = rar_pkg::STAT_OVF;
			pending.push_back(r);
			return;
		end
		neg = (nn != dn) && nm != 0;
		x = nm;
		y = dm;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		if (x == 0)
			x = 1;
		nm = nm / x;
		dm = dm / x;
		r.res_num = neg ? -nm : nm;
		r.res_den = dm[62:0];
		r.status = rar_pkg::STAT_OK;
		pending.push_back(r);
	endfunction

	task report(input string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	// Compares one result item with the oldest expectation.
	task check_result(input rar_pkg::rar_out_t got);
		rar_pkg::rar_out_t want;
		if (pending.size() == 0) begin
			report("result item with nothing expected");
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status)
			report($sformatf("status got %0d want %0d", got.status, want.status));
		if (got.res_num !== want.res_num)
			report($sformatf("res_num got %0d want %0d",
				$signed(got.res_num), $signed(want.res_num)));
		if (got.res_den !== want.res_den)
			report($sformatf("res_den got %0d want %0d", got.res_den, want.res_den));
	endtask
endclass

module testbench;
	import rar_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 800;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	rar_in_t req_item;
	logic rsp_valid;
	logic rsp_stall;
	rar_out_t rsp_item;

	fraction_board board;
	int idle_cycles;
	int burst_left;
	int stall_mode;

	rational_arith_reduce dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Operand with a bias toward the extremes and small magnitudes.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(0, 20)) - 10);
			3, 4: return 32'(int'($urandom_range(0, 2000)) - 1000);
			5: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// Offers one request item and holds it until it is taken.
	task automatic send_item(input rar_in_t it);
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		board.note_request(it);
	endtask

	// Sends one item, inserting a random gap at the end of each burst.
	task automatic send_paced(input rar_in_t it);
		int gap;
		send_item(it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	function automatic rar_in_t mk(logic [1:0] k, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		rar_in_t it;
		it.kind = k;
		it.a_num = an;
		it.a_den = ad;
		it.b_num = bn;
		it.b_den = bd;
		return it;
	endfunction

	// Receiver stalls in a pattern that changes mode every so often.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 499) == 0)
				stall_mode <= int'($urandom_range(0, 3));
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= $urandom_range(0, 3) == 0;
				2: rsp_stall <= $urandom_range(0, 3) != 0;
				default: rsp_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Result checking and watchdog on cycles with no accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				board.check_result(rsp_item);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("rational_arith_reduce: mismatch");
				$finish;
			end
		end
	end

	// Stimulus: directed corners, then random bursts.
	initial begin
		rar_in_t it;
		rar_in_t a_set[$];
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every operation, zero denominators, divide by zero, the overflow case,
		// zero results, sign handling and extreme operands.
		a_set.push_back(mk(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
		a_set.push_back(mk(KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2));
		a_set.push_back(mk(KIND_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9));
		a_set.push_back(mk(KIND_DIV, 32'd5, -32'sd6, -32'sd10, 32'd3));
		a_set.push_back(mk(KIND_ADD, 32'd1, 32'd0, 32'd1, 32'd3));
		a_set.push_back(mk(KIND_MUL, 32'd1, 32'd3, 32'd1, 32'd0));
		a_set.push_back(mk(KIND_DIV, 32'd1, 32'd3, 32'd0, 32'd7));
		a_set.push_back(mk(KIND_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		a_set.push_back(mk(KIND_SUB, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		a_set.push_back(mk(KIND_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff));
		a_set.push_back(mk(KIND_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff));
		a_set.push_back(mk(KIND_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff));
		a_set.push_back(mk(KIND_SUB, 32'h7fff_ffff, 32'h1, 32'h8000_0000, 32'h1));
		a_set.push_back(mk(KIND_MUL, 32'd0, 32'd5, 32'd7, 32'd9));
		a_set.push_back(mk(KIND_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff));
		a_set.push_back(mk(KIND_ADD, 32'hffff_fffe, 32'd4, 32'd0, 32'hffff_ffff));
		foreach (a_set[i])
			send_paced(a_set[i]);

		// Hold off until every expected result has come back.
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it.kind = 2'($urandom_range(0, 3));
			it.a_num = pick_word();
			it.b_num = pick_word();
			// Zero denominators only now and then.
			it.a_den = pick_word();
			it.b_den = pick_word();
			if (it.a_den == 0 && $urandom_range(0, 3) != 0)
				it.a_den = 32'd1;
			if (it.b_den == 0 && $urandom_range(0, 3) != 0)
				it.b_den = 32'hffff_ffff;
			send_paced(it);
			if (n == RANDOM_ITEMS / 2) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (board.pending.size() != 0)
					@(posedge clk);
			end
		end
		req_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("rational_arith_reduce: match");
		else
			$display("rational_arith_reduce: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
